// ===== src/rtces_pkg.sv =====
// Shared types, codes and arithmetic constants for the epoch seconds clock.
`timescale 1ns / 1ps

package rtces_pkg;

    // Input item function codes; the two unused codes behave as reads.
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_LOAD = 2'd1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BCD_INPUT        = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 1'b1;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] TPS_RESET = 8'd100;

    // Calendar arithmetic.
    localparam logic [11:0] YEAR_BASE     = 12'd2000;
    localparam logic [12:0] JD_YEAR_SHIFT = 13'd4800;
    localparam logic [12:0] CENTURY_SHIFT = 13'd100;
    localparam logic [7:0]  MONTH_SHIFT   = 8'd14;
    localparam logic [23:0] JD_YEAR_MUL   = 24'd1461;
    localparam logic [13:0] JD_MONTH_MUL  = 14'd367;
    // Combined bias: the formula's 32075 plus the day number of 1970-01-01.
    localparam logic [22:0] JD_BIAS       = 23'd2472663;
    localparam int          DAYS_W        = 17;
    localparam logic [33:0] SECS_PER_DAY  = 34'd86400;
    // Day number of 1970-01-01 plus one, modulo seven.
    localparam logic [17:0] WEEKDAY_BIAS  = 18'd4;

    // Reciprocals for division by constants, exact over the operand ranges used here.
    localparam logic [15:0] RECIP12_NARROW = 16'd171;     // x/12, x < 256, shift 11
    localparam logic [27:0] RECIP12_WIDE   = 28'd10923;   // x/12, x < 16384, shift 17
    localparam logic [25:0] RECIP100       = 26'd5243;    // x/100, x < 8192, shift 19
    localparam logic [36:0] RECIP7         = 37'd299594;  // x/7, x < 262144, shift 21

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_A,
        ST_STEP_B,
        ST_STEP_C,
        ST_STEP_D
    } rtces_state_t;

    typedef struct packed {
        logic tick;
        logic read;
        logic capture;
        logic step_a;
        logic step_b;
        logic step_c;
        logic finish;
    } rtces_cmd_t;

    typedef struct packed {
        logic out_busy;
    } rtces_status_t;

endpackage

// ===== src/rtces_ctrl.sv =====
// Controller state machine: accepts items and sequences the date conversion steps.
`timescale 1ns / 1ps

module rtces_ctrl
    import rtces_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_func,
    input  rtces_status_t status,
    output rtces_cmd_t    cmd
);

    rtces_state_t state_reg;
    rtces_state_t state_next;
    logic         fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (fire && (s_func == FUNC_LOAD)) begin
                    state_next = ST_STEP_A;
                end
            end
            ST_STEP_A: state_next = ST_STEP_B;
            ST_STEP_B: state_next = ST_STEP_C;
            ST_STEP_C: state_next = ST_STEP_D;
            ST_STEP_D: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = aresetn && (state_reg == ST_IDLE) && !status.out_busy;
        fire        = s_valid && s_ready;
        cmd         = '0;
        cmd.tick    = fire && (s_func == FUNC_TICK);
        cmd.capture = fire && (s_func == FUNC_LOAD);
        cmd.read    = fire && (s_func != FUNC_TICK) && (s_func != FUNC_LOAD);
        cmd.step_a  = (state_reg == ST_STEP_A);
        cmd.step_b  = (state_reg == ST_STEP_B);
        cmd.step_c  = (state_reg == ST_STEP_C);
        cmd.finish  = (state_reg == ST_STEP_D);
    end

    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_STEP_A))
        else $error("load item did not start the conversion sequence");

    a_sequence_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP_A) |=> (state_reg == ST_STEP_B) ##1 (state_reg == ST_STEP_C)
        ##1 (state_reg == ST_STEP_D) ##1 (state_reg == ST_IDLE))
        else $error("conversion sequence broke off");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input ready during a conversion");

endmodule

// ===== src/rtces_datapath.sv =====
// Datapath: clock state, configuration registers and the date to seconds conversion.
`timescale 1ns / 1ps

module rtces_datapath
    import rtces_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rtces_cmd_t             cmd,
    output rtces_status_t          status,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]             s_second_byte,
    input  logic [7:0]             s_minute_byte,
    input  logic [7:0]             s_hour_byte,
    input  logic [7:0]             s_day_byte,
    input  logic [7:0]             s_month_byte,
    input  logic [7:0]             s_year_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_epoch_seconds,
    output logic [2:0]             m_weekday,
    output logic [31:0]            m_tick_total,
    output logic [7:0]             m_sub_second
);

    // Clock state and configuration.
    logic [31:0] seconds_count_reg, seconds_count_next;
    logic [31:0] tick_count_reg, tick_count_next;
    logic [7:0]  tick_phase_reg, tick_phase_next;
    logic [2:0]  day_of_week_reg, day_of_week_next;
    logic        m_valid_reg, m_valid_next;
    logic        bcd_input_reg;
    logic [7:0]  tps_reg;

    // Conversion intermediates.
    logic [7:0]        sec_reg, min_reg, hr_reg, day_reg, mon_reg;
    logic [11:0]       yr_reg;
    logic [12:0]       ya_reg, ya_next;
    logic [4:0]        k_reg, k_next;
    logic [19:0]       tod_reg, tod_next;
    logic [21:0]       t1_reg, t1_next;
    logic [13:0]       num2_reg, num2_next;
    logic [6:0]        cent_reg, cent_next;
    logic [DAYS_W-1:0] days_reg, days_next;

    logic [8:0]  limit;
    logic [8:0]  phase_inc;
    logic        phase_wrap;
    logic [7:0]  mon_off;
    logic [15:0] q12_prod;
    logic [4:0]  q12;
    logic [7:0]  k_wide;
    logic [23:0] t1_prod;
    logic [12:0] yc;
    logic [25:0] cent_prod;
    logic [27:0] t2_prod;
    logic [10:0] t2;
    logic [8:0]  cent3;
    logic [22:0] days_full;
    logic [33:0] secs_prod;
    logic [31:0] secs_new;
    logic [17:0] wd_x;
    logic [36:0] wd_prod;
    logic [15:0] wd_q;
    logic [17:0] wd_r;

    function automatic logic [7:0] bcd_decode(input logic [7:0] b, input logic bcd);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        if (bcd) begin
            return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
        end
        return b;
    endfunction

    // Tick update: a zero limit register means 256 ticks per second.
    always_comb begin
        limit      = (tps_reg == 8'd0) ? 9'd256 : {1'b0, tps_reg};
        phase_inc  = {1'b0, tick_phase_reg} + 9'd1;
        phase_wrap = (phase_inc >= limit);
    end

    // Step A: month correction term and time of day.
    always_comb begin
        mon_off  = mon_reg - MONTH_SHIFT;
        q12_prod = 16'(mon_off) * RECIP12_NARROW;
        q12      = q12_prod[15:11];
        k_wide   = 8'd0;
        priority if (mon_reg < 8'd3) begin
            ya_next = 13'(yr_reg) + JD_YEAR_SHIFT - 13'd1;
            k_wide  = mon_reg + 8'd10;
        end else if (mon_reg < MONTH_SHIFT) begin
            ya_next = 13'(yr_reg) + JD_YEAR_SHIFT;
            k_wide  = mon_reg - 8'd2;
        end else begin
            ya_next = 13'(yr_reg) + JD_YEAR_SHIFT + 13'(q12);
            k_wide  = mon_reg - 8'd2 - 8'(8'(q12) * 8'd12);
        end
        k_next   = k_wide[4:0];
        tod_next = 20'(hr_reg) * 20'd3600 + 20'(min_reg) * 20'd60 + 20'(sec_reg);
    end

    // Step B: year and month products, century count.
    always_comb begin
        t1_prod   = 24'(ya_reg) * JD_YEAR_MUL;
        t1_next   = t1_prod[23:2];
        num2_next = 14'(k_reg) * JD_MONTH_MUL;
        yc        = ya_reg + CENTURY_SHIFT;
        cent_prod = 26'(yc) * RECIP100;
        cent_next = cent_prod[25:19];
    end

    // Step C: day count since 1970-01-01.
    always_comb begin
        t2_prod   = 28'(num2_reg) * RECIP12_WIDE;
        t2        = t2_prod[27:17];
        cent3     = 9'(cent_reg) * 9'd3;
        days_full = 23'(t1_reg) + 23'(t2) + 23'(day_reg) - 23'(cent3[8:2]) - JD_BIAS;
        days_next = days_full[DAYS_W-1:0];
    end

    // Step D: seconds and weekday.
    always_comb begin
        secs_prod = 34'(days_reg) * SECS_PER_DAY;
        secs_new  = secs_prod[31:0] + 32'(tod_reg);
        wd_x      = 18'(days_reg) + WEEKDAY_BIAS;
        wd_prod   = 37'(wd_x) * RECIP7;
        wd_q      = wd_prod[36:21];
        wd_r      = wd_x - 18'(18'(wd_q) * 18'd7);
    end

    always_comb begin
        seconds_count_next = seconds_count_reg;
        tick_count_next    = tick_count_reg;
        tick_phase_next    = tick_phase_reg;
        day_of_week_next   = day_of_week_reg;
        if (cmd.tick) begin
            tick_count_next = tick_count_reg + 32'd1;
            if (phase_wrap) begin
                tick_phase_next    = 8'd0;
                seconds_count_next = seconds_count_reg + 32'd1;
            end else begin
                tick_phase_next = phase_inc[7:0];
            end
        end
        if (cmd.finish) begin
            seconds_count_next = secs_new;
            day_of_week_next   = wd_r[2:0];
        end
        m_valid_next = (m_valid_reg && !m_ready) || cmd.tick || cmd.read || cmd.finish;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seconds_count_reg <= '0;
            tick_count_reg    <= '0;
            tick_phase_reg    <= '0;
            day_of_week_reg   <= '0;
            m_valid_reg       <= 1'b0;
            bcd_input_reg     <= 1'b0;
            tps_reg           <= TPS_RESET;
        end else begin
            seconds_count_reg <= seconds_count_next;
            tick_count_reg    <= tick_count_next;
            tick_phase_reg    <= tick_phase_next;
            day_of_week_reg   <= day_of_week_next;
            m_valid_reg       <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BCD_INPUT:        bcd_input_reg <= cfg_data[0];
                    CFG_TICKS_PER_SECOND: tps_reg       <= cfg_data;
                    default:              tps_reg       <= tps_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sec_reg <= bcd_decode(s_second_byte, bcd_input_reg);
            min_reg <= bcd_decode(s_minute_byte, bcd_input_reg);
            hr_reg  <= bcd_decode(s_hour_byte, bcd_input_reg);
            day_reg <= bcd_decode(s_day_byte, bcd_input_reg);
            mon_reg <= bcd_decode(s_month_byte, bcd_input_reg);
            yr_reg  <= YEAR_BASE + 12'(bcd_decode(s_year_byte, bcd_input_reg));
        end
        if (cmd.step_a) begin
            ya_reg  <= ya_next;
            k_reg   <= k_next;
            tod_reg <= tod_next;
        end
        if (cmd.step_b) begin
            t1_reg   <= t1_next;
            num2_reg <= num2_next;
            cent_reg <= cent_next;
        end
        if (cmd.step_c) begin
            days_reg <= days_next;
        end
    end

    // The state registers double as the result register: nothing changes them while
    // a result is pending, because no item is accepted until it is taken.
    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid         = m_valid_reg;
    assign m_epoch_seconds = seconds_count_reg;
    assign m_weekday       = day_of_week_reg;
    assign m_tick_total    = tick_count_reg;
    assign m_sub_second    = tick_phase_reg;

    a_finish_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !m_valid_reg)
        else $error("conversion finished while a result was still pending");

    a_tick_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick |=> (tick_count_reg == $past(tick_count_reg) + 32'd1))
        else $error("tick item did not advance the tick count");

    a_pending_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(seconds_count_reg) && $stable(tick_phase_reg)
        && $stable(tick_count_reg) && $stable(day_of_week_reg)))
        else $error("clock state changed under a pending result");

endmodule

// ===== src/rtc_epoch_seconds_clock.sv =====
// Top level of the epoch seconds clock: controller plus datapath.
`timescale 1ns / 1ps

// Seconds clock with a calendar loader. Each input item is a tick (func 0), a load of
// date and time (func 1) or a read (func 2 or 3), and each returns one result item with
// the seconds since 1970, the weekday of the last loaded date, the tick total and the
// sub-second count as they stand after the item. A load captures the decoded bytes and
// then runs the four-step date conversion sequence, during which no item is accepted.
// An item is accepted only once the previous result has been taken, which may happen in
// the same cycle. Configuration writes take effect at once and are meant for an idle
// block; a ticks_per_second of zero counts as 256.
module rtc_epoch_seconds_clock
    import rtces_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_func,
    input  logic [7:0]             s_second_byte,
    input  logic [7:0]             s_minute_byte,
    input  logic [7:0]             s_hour_byte,
    input  logic [7:0]             s_day_byte,
    input  logic [7:0]             s_month_byte,
    input  logic [7:0]             s_year_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_epoch_seconds,
    output logic [2:0]             m_weekday,
    output logic [31:0]            m_tick_total,
    output logic [7:0]             m_sub_second
);

    rtces_cmd_t    cmd;
    rtces_status_t status;

    rtces_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    rtces_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_second_byte   (s_second_byte),
        .s_minute_byte   (s_minute_byte),
        .s_hour_byte     (s_hour_byte),
        .s_day_byte      (s_day_byte),
        .s_month_byte    (s_month_byte),
        .s_year_byte     (s_year_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_epoch_seconds (m_epoch_seconds),
        .m_weekday       (m_weekday),
        .m_tick_total    (m_tick_total),
        .m_sub_second    (m_sub_second)
    );

endmodule

// ===== tb/tb_clock_pkg.sv =====
// Item and reading types plus the scoreboard class for the epoch seconds clock testbench.
`timescale 1ns / 1ps

package tb_clock_pkg;
    import rtces_pkg::*;

    // Read codes; the spare code must behave exactly like a read.
    localparam logic [1:0] FUNC_READ       = 2'd2;
    localparam logic [1:0] FUNC_READ_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
    } clock_item_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic [2:0]  weekday;
        logic [31:0] ticks;
        logic [7:0]  sub_second;
    } clock_reading_t;

    class clock_scoreboard;
        bit             bcd_mode;
        bit [7:0]       ticks_per_sec;
        bit [31:0]      seconds;
        bit [31:0]      ticks;
        bit [7:0]       phase;
        bit [2:0]       weekday;
        clock_reading_t readings_q[$];
        int             mismatches;

        function new();
            bcd_mode      = 1'b0;
            ticks_per_sec = TPS_RESET;
            seconds       = '0;
            ticks         = '0;
            phase         = '0;
            weekday       = '0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_BCD_INPUT) begin
                bcd_mode = val[0];
            end else if (idx == CFG_TICKS_PER_SECOND) begin
                ticks_per_sec = val;
            end
        endfunction

        function int decode(logic [7:0] b);
            if (bcd_mode) begin
                return int'(b[7:4]) * 10 + int'(b[3:0]);
            end
            return int'(b);
        endfunction

        // Integer division on int truncates toward zero, as the formula requires.
        function int day_number(int m, int d, int y);
            int a;
            a = (m - 14) / 12;
            return (1461 * (y + 4800 + a)) / 4
                 + (367 * (m - 2 - 12 * a)) / 12
                 - (3 * ((y + 4900 + a) / 100)) / 4
                 + d - 32075;
        endfunction

        function void note_item(clock_item_t it);
            int             limit;
            int             jd;
            int             tod;
            bit [31:0]      days;
            clock_reading_t r;
            case (it.func)
                FUNC_TICK: begin
                    limit = (ticks_per_sec == 0) ? 256 : int'(ticks_per_sec);
                    ticks++;
                    if (int'(phase) + 1 >= limit) begin
                        phase = '0;
                        seconds++;
                    end else begin
                        phase = phase + 8'd1;
                    end
                end
                FUNC_LOAD: begin
                    jd = day_number(decode(it.month), decode(it.day), decode(it.year) + 2000);
                    days = jd - day_number(1, 1, 1970);
                    tod = decode(it.hour) * 3600 + decode(it.minute) * 60 + decode(it.second);
                    seconds = days * 32'd86400 + 32'(tod);
                    weekday = 3'((jd + 1) % 7);
                end
                default: begin
                end
            endcase
            r.epoch      = seconds;
            r.weekday    = weekday;
            r.ticks      = ticks;
            r.sub_second = phase;
            readings_q.push_back(r);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %s: expected %0d, got %0d", field, want, got);
            end
        endfunction

        function void check_result(clock_reading_t got);
            clock_reading_t want;
            if (readings_q.size() == 0) begin
                flag("result with no item pending", 0, got.epoch);
                return;
            end
            want = readings_q.pop_front();
            if (got.epoch !== want.epoch) flag("epoch_seconds", want.epoch, got.epoch);
            if (got.weekday !== want.weekday) flag("weekday", want.weekday, got.weekday);
            if (got.ticks !== want.ticks) flag("tick_total", want.ticks, got.ticks);
            if (got.sub_second !== want.sub_second) begin
                flag("sub_second", want.sub_second, got.sub_second);
            end
        endfunction

        function int pending();
            return readings_q.size();
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for the epoch seconds clock: stimulus, handshake drivers and checking.
`timescale 1ns / 1ps

module tb_top;
    import rtces_pkg::*;
    import tb_clock_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [1:0]             s_func;
    logic [7:0]             s_second_byte;
    logic [7:0]             s_minute_byte;
    logic [7:0]             s_hour_byte;
    logic [7:0]             s_day_byte;
    logic [7:0]             s_month_byte;
    logic [7:0]             s_year_byte;
    logic                   m_valid;
    logic                   m_ready;
    logic [31:0]            m_epoch_seconds;
    logic [2:0]             m_weekday;
    logic [31:0]            m_tick_total;
    logic [7:0]             m_sub_second;

    int              sender_idle_pct = 0;
    int              receiver_stall_pct = 0;
    int unsigned     cycle_count = 0;
    clock_scoreboard sb;

    rtc_epoch_seconds_clock u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_second_byte   (s_second_byte),
        .s_minute_byte   (s_minute_byte),
        .s_hour_byte     (s_hour_byte),
        .s_day_byte      (s_day_byte),
        .s_month_byte    (s_month_byte),
        .s_year_byte     (s_year_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_epoch_seconds (m_epoch_seconds),
        .m_weekday       (m_weekday),
        .m_tick_total    (m_tick_total),
        .m_sub_second    (m_sub_second)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rtc_epoch_seconds_clock test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(clock_reading_t'{m_epoch_seconds, m_weekday, m_tick_total,
                                             m_sub_second});
        end
    end

    // Lowers valid and returns once every accepted item has produced its reading.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_regs(input bit bcd, input logic [7:0] tps);
        wait_drained();
        write_reg(CFG_BCD_INPUT, {7'd0, bcd});
        write_reg(CFG_TICKS_PER_SECOND, tps);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input clock_item_t it);
        int gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= it.func;
        s_second_byte <= it.second;
        s_minute_byte <= it.minute;
        s_hour_byte   <= it.hour;
        s_day_byte    <= it.day;
        s_month_byte  <= it.month;
        s_year_byte   <= it.year;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
    endtask

    function automatic clock_item_t make_item(logic [1:0] f, logic [7:0] yr, logic [7:0] mo,
                                              logic [7:0] dy, logic [7:0] hr, logic [7:0] mn,
                                              logic [7:0] sc);
        return clock_item_t'{f, sc, mn, hr, dy, mo, yr};
    endfunction

    function automatic logic [7:0] to_bcd(int v);
        return 8'((v / 10) * 16 + v % 10);
    endfunction

    function automatic logic [7:0] calendar_byte(bit bcd, int v);
        return bcd ? to_bcd(v) : 8'(v);
    endfunction

    function automatic clock_item_t random_item(bit bcd, int tick_pct);
        clock_item_t it;
        int          kind;
        it.second = 8'($urandom);
        it.minute = 8'($urandom);
        it.hour   = 8'($urandom);
        it.day    = 8'($urandom);
        it.month  = 8'($urandom);
        it.year   = 8'($urandom);
        if ($urandom_range(99) < tick_pct) begin
            it.func = FUNC_TICK;
            return it;
        end
        kind = $urandom_range(99);
        if (kind < 60) begin
            it.func   = FUNC_LOAD;
            it.year   = calendar_byte(bcd, $urandom_range(99));
            it.month  = calendar_byte(bcd, $urandom_range(1, 12));
            it.day    = calendar_byte(bcd, $urandom_range(1, 31));
            it.hour   = calendar_byte(bcd, $urandom_range(23));
            it.minute = calendar_byte(bcd, $urandom_range(59));
            it.second = calendar_byte(bcd, $urandom_range(59));
        end else if (kind < 85) begin
            it.func = $urandom_range(1) ? FUNC_READ : FUNC_READ_SPARE;
        end else begin
            // Raw bytes: out-of-range fields and broken BCD digits.
            it.func = FUNC_LOAD;
        end
        return it;
    endfunction

    initial begin
        int         n;
        int         tick_pct;
        bit         bcd;
        logic [7:0] tps;

        sb            = new();
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_func        <= FUNC_TICK;
        s_second_byte <= '0;
        s_minute_byte <= '0;
        s_hour_byte   <= '0;
        s_day_byte    <= '0;
        s_month_byte  <= '0;
        s_year_byte   <= '0;
        m_ready       <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        program_regs(1'b0, TPS_RESET);
        send_item(make_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_item(make_item(FUNC_READ_SPARE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_item(make_item(FUNC_LOAD, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0));
        send_item(make_item(FUNC_LOAD, 8'd99, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59));
        send_item(make_item(FUNC_LOAD, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_item(make_item(FUNC_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        // 2106-02-07 06:28:15 is the last second before the 32-bit count wraps.
        send_item(make_item(FUNC_LOAD, 8'd106, 8'd2, 8'd7, 8'd6, 8'd28, 8'd15));
        program_regs(1'b0, 8'd1);
        send_item(make_item(FUNC_TICK, 8'h5a, 8'ha5, 8'h3c, 8'hc3, 8'h0f, 8'hf0));
        send_item(make_item(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

        program_regs(1'b1, 8'd2);
        send_item(make_item(FUNC_LOAD, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
        send_item(make_item(FUNC_LOAD, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_item(make_item(FUNC_LOAD, 8'ha5, 8'h1f, 8'h0c, 8'hb9, 8'h7a, 8'hee));
        repeat (3) send_item(make_item(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

        // Leave the phase above a smaller ticks_per_second, then tick past it.
        program_regs(1'b0, 8'd8);
        repeat (6) send_item(make_item(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        program_regs(1'b0, 8'd3);
        repeat (2) send_item(make_item(FUNC_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

        for (int p = 0; p < 7; p++) begin
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 74;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 74;
                end
                default: begin
                    sender_idle_pct = 14;
                    receiver_stall_pct = 14;
                end
            endcase
            case (p)
                0: begin bcd = 1'b0; tps = 8'd100; end
                1: begin bcd = 1'b1; tps = 8'd1; end
                2: begin bcd = 1'b0; tps = 8'd255; end
                3: begin bcd = 1'b1; tps = 8'd0; end
                4: begin bcd = 1'b0; tps = 8'($urandom_range(2, 254)); end
                5: begin bcd = 1'b1; tps = 8'($urandom_range(1, 20)); end
                default: begin bcd = 1'b1; tps = 8'd7; end
            endcase
            program_regs(bcd, tps);
            // A zero setting needs 256 ticks to roll over, so that phase runs longer.
            n = (tps == 0) ? 300 : 105;
            tick_pct = (tps == 0 || tps > 100) ? 95 : 55;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(99) == 0) wait_drained();
                send_item(random_item(bcd, tick_pct));
            end
        end

        receiver_stall_pct = 0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("rtc_epoch_seconds_clock test passed");
        end else begin
            $display("rtc_epoch_seconds_clock test failed");
        end
        $finish;
    end

endmodule
